[sv/greedy_job_shop_scheduler_defines.svh]
// Assertion macros for the greedy job shop scheduler checker.
// Used only by the checker file; expects a clock i_clk and reset i_rst_n in scope.
`ifndef GREEDY_JOB_SHOP_SCHEDULER_DEFINES_SVH
`define GREEDY_JOB_SHOP_SCHEDULER_DEFINES_SVH

// Implication in the same cycle, disabled during reset.
`define GJSS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gjss assertion failed");

// Implication checked in the next cycle, disabled during reset.
`define GJSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gjss assertion failed");

`endif

[sv/gjss_pkg.sv]
// Shared constants for the greedy job shop scheduler.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package gjss_pkg;

    localparam int TIME_BITS = 24;
    localparam logic [TIME_BITS-1:0] TIME_MAX = 24'hFFFFFF;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_RUN  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    localparam logic REG_JOB_COUNT     = 1'b0;
    localparam logic REG_MACHINE_COUNT = 1'b1;

    localparam logic [4:0] JOB_COUNT_RESET     = 5'd16;
    localparam logic [4:0] MACHINE_COUNT_RESET = 5'd16;

endpackage

[sv/greedy_job_shop_scheduler.sv]
// Channel     | Signals                                   | Accepted when
// request     | start, busy, i_req_type .. i_op_duration  | start && !busy
// result      | o_valid, o_result_value, o_status         | o_valid (no stall)
// config      | psel, penable, pwrite, paddr, pwdata      | psel && penable && pwrite
//
// A load or an unknown request keeps busy low, and its word appears the next cycle.
// A read holds busy for one cycle in S_RD, and S_RD then registers its word onto the result.
// A run passes a setup state, then rounds over J jobs: a load pass, then per active job a
// compare loop over all J jobs and, unless blocked, a placement; a final makespan sweep visits each machine slot.
// Reset is synchronous and active low; the memories need no clearing.
// The receiver cannot stall, so each result is shown for exactly one cycle.
// Greedy job shop scheduler top level. Depends on gjss_pkg.
`timescale 1ns / 1ps

module greedy_job_shop_scheduler #(
    parameter int JOB_SLOTS     = 16,
    parameter int MAX_MACHINES  = 16,
    parameter int DURATION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_job_index,
    input  logic [3:0]  i_op_index,
    input  logic [3:0]  i_op_machine,
    input  logic [15:0] i_op_duration,
    output logic        o_valid,
    output logic [23:0] o_result_value,
    output logic        o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TB    = gjss_pkg::TIME_BITS;
    localparam int DW    = DURATION_BITS;
    localparam int SW    = ((DW > TB) ? DW : TB) + 1;
    localparam int CELLS = JOB_SLOTS * MAX_MACHINES;
    localparam int AW    = $clog2(CELLS);
    localparam int JW    = $clog2(JOB_SLOTS);
    localparam int JCW   = $clog2(JOB_SLOTS + 1);
    localparam int KCW   = $clog2(MAX_MACHINES + 1);
    localparam int MW    = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int RW    = $clog2(CELLS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_INIT, S_LOAD, S_LOADW, S_SEL, S_CMP,
        S_PREV, S_WAIT, S_PLACE, S_MAX
    } t_state;

    typedef logic [MW-1:0] t_mod_tbl [16];

    function automatic t_mod_tbl mod_table();
        t_mod_tbl tbl;
        for (int v = 0; v < 16; v++) begin
            tbl[v] = MW'(v % MAX_MACHINES);
        end
        return tbl;
    endfunction

    localparam t_mod_tbl MOD_TBL = mod_table();

    function automatic logic [AW-1:0] cell_addr(input int job, input int k);
        return AW'(job * MAX_MACHINES + k);
    endfunction

    function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] a,
                                             input logic [DW-1:0] b);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(b);
        return (s > SW'(gjss_pkg::TIME_MAX)) ? gjss_pkg::TIME_MAX : TB'(s);
    endfunction

    function automatic int clamp(input logic [4:0] v, input int hi);
        if (v == 5'd0) return 1;
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    t_state r_state;

    logic [4:0] r_job_count;
    logic [4:0] r_machine_count;

    logic [MW+DW-1:0] r_op_mem [CELLS];
    logic [TB-1:0]    r_start  [CELLS];
    logic [MW+DW-1:0] r_op_q;
    logic [TB-1:0]    r_start_q;

    logic [TB-1:0]  r_mft     [MAX_MACHINES];
    logic [KCW-1:0] r_adv     [JOB_SLOTS];
    logic [MW-1:0]  r_cur_mach[JOB_SLOTS];
    logic [DW-1:0]  r_cur_dur [JOB_SLOTS];
    logic [KCW-1:0] r_cur_k   [JOB_SLOTS];
    logic           r_cur_act [JOB_SLOTS];

    logic [JCW-1:0] r_jobs;
    logic [KCW-1:0] r_ops;
    logic [RW-1:0]  r_rem;
    logic [JW-1:0]  r_i;
    logic [JW-1:0]  r_j;
    logic [MW-1:0]  r_m;
    logic [DW-1:0]  r_d;
    logic [KCW-1:0] r_k;
    logic           r_blk;
    logic [TB-1:0]  r_prev;
    logic [MW-1:0]  r_sw;
    logic [TB-1:0]  r_best;
    logic           r_sched_valid;
    logic           r_rd_ok;
    logic           r_rd_stat;
    logic           r_valid;
    logic [TB-1:0]  r_value;
    logic           r_status;

    logic           w_accept;
    logic           w_in_range;
    logic           w_cfg_wr;
    logic [JW-1:0]  w_ridx;
    logic [MW-1:0]  w_midx;
    logic [TB-1:0]  w_mft;
    logic [KCW-1:0] w_load_k;
    logic           w_load_act;
    logic [AW-1:0]  w_op_raddr;
    logic [AW-1:0]  w_st_raddr;
    logic [AW-1:0]  w_prev_cell;
    logic [TB-1:0]  w_start;
    logic [RW-1:0]  w_rem_after;
    logic           w_last_i;
    logic           w_last_j;
    logic [MW-1:0]  w_op_mach_q;
    logic [DW-1:0]  w_op_dur_q;

    assign w_accept   = start && (r_state == S_IDLE);
    assign w_in_range = (int'(i_job_index) < JOB_SLOTS) && (int'(i_op_index) < MAX_MACHINES);
    assign w_cfg_wr   = psel && penable && pwrite;
    assign busy       = (r_state != S_IDLE);
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == gjss_pkg::REG_MACHINE_COUNT) ?
                        {27'd0, r_machine_count} : {27'd0, r_job_count};

    assign w_op_mach_q = r_op_q[MW+DW-1:DW];
    assign w_op_dur_q  = r_op_q[DW-1:0];
    assign w_ridx      = (r_state == S_SEL) ? r_i : r_j;
    assign w_midx      = (r_state == S_MAX) ? r_sw : r_m;
    assign w_mft       = r_mft[w_midx];
    assign w_load_k    = r_adv[r_j];
    assign w_load_act  = (w_load_k < r_ops);
    assign w_prev_cell = cell_addr(int'(r_i), int'(r_k) - 1);
    assign w_op_raddr  = (r_state == S_LOAD) ?
                         cell_addr(int'(r_j), w_load_act ? int'(w_load_k) : 0) : w_prev_cell;
    assign w_st_raddr  = (r_state == S_IDLE) ?
                         cell_addr(int'(i_job_index), int'(i_op_index)) : w_prev_cell;
    assign w_start     = (w_mft > r_prev) ? w_mft : r_prev;
    assign w_rem_after = (r_state == S_PLACE) ? (r_rem - RW'(1)) : r_rem;
    assign w_last_i    = (JCW'(r_i) == r_jobs - JCW'(1));
    assign w_last_j    = (JCW'(r_j) == r_jobs - JCW'(1));

    assign o_valid        = r_valid;
    assign o_result_value = r_value;
    assign o_status       = r_status;

    always_ff @(posedge i_clk) begin
        r_op_q    <= r_op_mem[w_op_raddr];
        r_start_q <= r_start[w_st_raddr];
        if (w_accept && (i_req_type == gjss_pkg::REQ_LOAD) && w_in_range) begin
            r_op_mem[cell_addr(int'(i_job_index), int'(i_op_index))] <=
                {MOD_TBL[i_op_machine], DW'(i_op_duration)};
        end
        if (r_state == S_PLACE) begin
            r_start[cell_addr(int'(r_i), int'(r_k))] <= w_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_count     <= gjss_pkg::JOB_COUNT_RESET;
            r_machine_count <= gjss_pkg::MACHINE_COUNT_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == gjss_pkg::REG_MACHINE_COUNT) begin
                r_machine_count <= pwdata[4:0];
            end else begin
                r_job_count <= pwdata[4:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_valid       <= 1'b0;
            r_sched_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (i_req_type)
                            gjss_pkg::REQ_RUN: begin
                                r_jobs  <= JCW'(clamp(r_job_count, JOB_SLOTS));
                                r_ops   <= KCW'(clamp(r_machine_count, MAX_MACHINES));
                                r_state <= S_INIT;
                            end
                            gjss_pkg::REQ_READ: begin
                                r_rd_ok   <= r_sched_valid && w_in_range;
                                r_rd_stat <= !r_sched_valid;
                                r_state   <= S_RD;
                            end
                            default: begin
                                r_valid  <= 1'b1;
                                r_value  <= '0;
                                r_status <= 1'b0;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_valid  <= 1'b1;
                    r_value  <= r_rd_ok ? r_start_q : '0;
                    r_status <= r_rd_stat;
                    r_state  <= S_IDLE;
                end
                S_INIT: begin
                    for (int m = 0; m < MAX_MACHINES; m++) begin
                        r_mft[m] <= '0;
                    end
                    for (int j = 0; j < JOB_SLOTS; j++) begin
                        r_adv[j] <= '0;
                    end
                    r_rem   <= RW'(r_jobs) * RW'(r_ops);
                    r_j     <= '0;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_state <= S_LOADW;
                end
                S_LOADW: begin
                    r_cur_mach[r_j] <= w_op_mach_q;
                    r_cur_dur[r_j]  <= w_op_dur_q;
                    r_cur_k[r_j]    <= w_load_k;
                    r_cur_act[r_j]  <= w_load_act;
                    if (w_last_j) begin
                        r_i     <= '0;
                        r_state <= S_SEL;
                    end else begin
                        r_j     <= r_j + JW'(1);
                        r_state <= S_LOAD;
                    end
                end
                S_SEL: begin
                    if (r_cur_act[w_ridx]) begin
                        r_m     <= r_cur_mach[w_ridx];
                        r_d     <= r_cur_dur[w_ridx];
                        r_k     <= r_cur_k[w_ridx];
                        r_blk   <= 1'b0;
                        r_j     <= '0;
                        r_state <= S_CMP;
                    end else if (!w_last_i) begin
                        r_i <= r_i + JW'(1);
                    end else if (w_rem_after == '0) begin
                        r_sw    <= '0;
                        r_best  <= '0;
                        r_state <= S_MAX;
                    end else begin
                        r_j     <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_CMP: begin
                    if ((w_ridx != r_i) && r_cur_act[w_ridx] &&
                        (r_cur_mach[w_ridx] == r_m) && (r_d > r_cur_dur[w_ridx])) begin
                        r_blk <= 1'b1;
                    end
                    if (w_last_j) begin
                        r_state <= S_PREV;
                    end else begin
                        r_j <= r_j + JW'(1);
                    end
                end
                S_PREV: begin
                    if (r_blk) begin
                        priority if (!w_last_i) begin
                            r_i     <= r_i + JW'(1);
                            r_state <= S_SEL;
                        end else if (w_rem_after == '0) begin
                            r_sw    <= '0;
                            r_best  <= '0;
                            r_state <= S_MAX;
                        end else begin
                            r_j     <= '0;
                            r_state <= S_LOAD;
                        end
                    end else if (r_k == '0) begin
                        r_prev  <= '0;
                        r_state <= S_PLACE;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_prev  <= sat_add(r_start_q, w_op_dur_q);
                    r_state <= S_PLACE;
                end
                S_PLACE: begin
                    r_mft[r_m] <= sat_add(w_start, r_d);
                    r_adv[r_i] <= r_k + KCW'(1);
                    r_rem      <= w_rem_after;
                    priority if (!w_last_i) begin
                        r_i     <= r_i + JW'(1);
                        r_state <= S_SEL;
                    end else if (w_rem_after == '0) begin
                        r_sw    <= '0;
                        r_best  <= '0;
                        r_state <= S_MAX;
                    end else begin
                        r_j     <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_MAX: begin
                    if (int'(r_sw) == MAX_MACHINES - 1) begin
                        r_valid       <= 1'b1;
                        r_value       <= (w_mft > r_best) ? w_mft : r_best;
                        r_status      <= 1'b0;
                        r_sched_valid <= 1'b1;
                        r_state       <= S_IDLE;
                    end else begin
                        r_best <= (w_mft > r_best) ? w_mft : r_best;
                        r_sw   <= r_sw + MW'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[sv/gjss_checker.sv]
// Port-level checker for the greedy job shop scheduler, with its bind.
// Depends on gjss_pkg and greedy_job_shop_scheduler_defines.svh.
`timescale 1ns / 1ps
`include "greedy_job_shop_scheduler_defines.svh"

module gjss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  i_req_type,
    input logic        o_valid,
    input logic [23:0] o_result_value,
    input logic        o_status
);

    logic w_acc_load;
    logic w_acc_run;
    logic w_acc_read;

    assign w_acc_load = start && !busy && (i_req_type == gjss_pkg::REQ_LOAD);
    assign w_acc_run  = start && !busy && (i_req_type == gjss_pkg::REQ_RUN);
    assign w_acc_read = start && !busy && (i_req_type == gjss_pkg::REQ_READ);

    `GJSS_ASSERT_NEXT(a_load_word, w_acc_load, o_valid && (o_result_value == 24'd0) && !o_status)
    `GJSS_ASSERT_NEXT(a_run_busy, w_acc_run, busy && !o_valid)
    `GJSS_ASSERT_SAME(a_status_zero, o_valid && o_status, o_result_value == 24'd0)
    `GJSS_ASSERT_NEXT(a_read_busy, w_acc_read, busy)

endmodule

bind greedy_job_shop_scheduler gjss_checker u_gjss_checker (.*);
